// File: rtl/core/mavf_pkg.sv
// ----------------------------------------------------------------------------
// mavf_pkg
// Shared widths, reset values and controller/datapath handshake types
// for the moving average filter.
// ----------------------------------------------------------------------------
package mavf_pkg;

   localparam int SAMPLE_W     = 12;
   localparam int COUNT_W      = 5;
   localparam int CFG_W        = 5;
   localparam int STEP_W       = $clog2(SAMPLE_W);
   localparam int RESET_WINDOW = 5;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [CFG_W-1:0]    cfg_type;

   typedef struct packed {
      logic take_req;
      logic cfg_write;
      logic update;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

// File: rtl/core/mavf_ifs.sv
// ----------------------------------------------------------------------------
// mavf channel interfaces
// Valid/ready channels for samples, results and the window size register.
// ----------------------------------------------------------------------------
interface mavf_req_if import mavf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mavf_rsp_if import mavf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type average;
   count_type  fill_count;

   modport source (output valid, output average, output fill_count, input ready);
   modport sink   (input valid, input average, input fill_count, output ready);
endinterface

interface mavf_csr_if import mavf_pkg::*; ();
   logic    valid;
   logic    ready;
   cfg_type window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

// File: rtl/core/mavf_ram.sv
// ----------------------------------------------------------------------------
// mavf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mavf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/mavf_ctrl.sv
// ----------------------------------------------------------------------------
// mavf_ctrl
// Sequencer: sample transfer, window update, divider run and result load.
// ----------------------------------------------------------------------------
module mavf_ctrl import mavf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       csr_valid,
   output logic       csr_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UPDATE = 3'd1;
   localparam logic [2:0] S_START  = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.cfg_write = csr_valid && csr_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.take_req = 1'b1;
               state_in     = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_START;
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/mavf_dp.sv
// ----------------------------------------------------------------------------
// mavf_dp
// Sample ring, running sum, fill count, write position, serial divider
// and result register.
// ----------------------------------------------------------------------------
module mavf_dp import mavf_pkg::*; #(
   parameter int MAX_WINDOW = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  sample_type req_sample,
   input  cfg_type    csr_window_size,
   output sample_type rsp_average,
   output count_type  rsp_fill_count
);

   localparam int EFF_MAX = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
   localparam int POS_W   = $clog2(MAX_WINDOW);
   localparam int SUM_W   = SAMPLE_W + $clog2(EFF_MAX);
   localparam int CMP_W   = (POS_W + 1 > COUNT_W) ? POS_W + 1 : COUNT_W;

   cfg_type           window_ff, window_in;
   count_type         active;
   logic              full;
   sample_type        sample_ff, sample_in;
   sample_type        ring_rd;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   count_type         count_ff, count_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CMP_W-1:0]  pos_plus;
   logic [SUM_W-1:0]  num;
   count_type         rem_ff, rem_in;
   sample_type        quo_ff, quo_in;
   logic [COUNT_W:0]  trial;
   logic [STEP_W-1:0] step_ff, step_in;
   sample_type        avg_ff, avg_in;
   count_type         fill_ff, fill_in;

   // window size clamp: zero acts as one, above the ring depth acts as the depth
   always_comb begin
      if (window_ff == '0) begin
         active = count_type'(1);
      end else if (int'(window_ff) > EFF_MAX) begin
         active = count_type'(EFF_MAX);
      end else begin
         active = window_ff;
      end
   end

   assign full     = (count_ff >= active);
   assign pos_plus = CMP_W'(pos_ff) + CMP_W'(1);
   assign num      = sum_ff + SUM_W'(count_ff >> 1);
   assign trial    = {rem_ff, quo_ff[SAMPLE_W-1]};

   mavf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.take_req),
      .rd_addr (pos_ff),
      .rd_data (ring_rd)
   );

   always_comb begin
      window_in = window_ff;
      sample_in = sample_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      avg_in    = avg_ff;
      fill_in   = fill_ff;

      if (cmd.cfg_write) begin
         window_in = csr_window_size;
         sum_in    = '0;
         count_in  = '0;
         pos_in    = '0;
      end

      if (cmd.take_req) begin
         sample_in = req_sample;
      end

      if (cmd.update) begin
         sum_in = sum_ff - (full ? SUM_W'(ring_rd) : '0) + SUM_W'(sample_ff);
         if (!full) begin
            count_in = count_ff + count_type'(1);
         end
         if (pos_plus >= CMP_W'(active)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_plus[POS_W-1:0];
         end
      end

      // quotient fits in a sample, so the upper part seeds the remainder
      if (cmd.div_start) begin
         rem_in  = count_type'(num >> SAMPLE_W);
         quo_in  = num[SAMPLE_W-1:0];
         step_in = '0;
      end

      if (cmd.div_step) begin
         if (trial >= {1'b0, count_ff}) begin
            rem_in = count_type'(trial - {1'b0, count_ff});
            quo_in = {quo_ff[SAMPLE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[COUNT_W-1:0];
            quo_in = {quo_ff[SAMPLE_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
      end

      if (cmd.out_load) begin
         avg_in  = quo_ff;
         fill_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= cfg_type'(RESET_WINDOW);
         sum_ff    <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
         step_ff   <= '0;
      end else begin
         window_ff <= window_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      avg_ff    <= avg_in;
      fill_ff   <= fill_in;
   end

   assign status.div_last = (step_ff == STEP_W'(SAMPLE_W - 1));
   assign rsp_average     = avg_ff;
   assign rsp_fill_count  = fill_ff;

endmodule

// File: rtl/core/moving_average_filter_top.sv
// ----------------------------------------------------------------------------
// moving_average_filter_top
// Simple moving average over the most recent 12-bit converter samples.
//
// req_bus carries one sample per transfer; rsp_bus returns one result per
// sample: the mean of the samples held, rounded half up, and the fill count.
// csr_bus writes the window size (1..16 effective, zero acts as one); any
// write empties the window. Write it only while no sample is in flight.
// Each result follows its transfer in these steps: the ring is read at the
// transfer, then one sum update, one divider load, twelve steps of the
// restoring divider (one quotient bit per cycle) and one result load. The
// next sample is taken the cycle after the result is loaded and not
// before, so samples are handled one at a time.
// The result sits in an output register; a stalled receiver holds it and
// the block still takes and works the next sample, then waits for the slot.
// Reset sets the window size to five and empties the window; the ring
// itself needs no clearing since entries are only read after being written.
// ----------------------------------------------------------------------------
module moving_average_filter_top import mavf_pkg::*; #(
   parameter int MAX_WINDOW = 16
) (
   input logic         clock,
   input logic         reset,
   mavf_req_if.sink    req_bus,
   mavf_rsp_if.source  rsp_bus,
   mavf_csr_if.sink    csr_bus
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       csr_ready;
   logic       rsp_valid;

   mavf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mavf_dp #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_bus.sample),
      .csr_window_size (csr_bus.window_size),
      .rsp_average     (rsp_bus.average),
      .rsp_fill_count  (rsp_bus.fill_count)
   );

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = csr_ready;
   assign rsp_bus.valid = rsp_valid;

   // one sample at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_ready) |=> !req_ready)
      else $error("sample taken while previous one in progress");

   assert property (@(posedge clock) disable iff (reset)
      !((req_bus.valid && req_ready) && (csr_bus.valid && csr_ready)))
      else $error("sample and register transfer in the same cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bus.fill_count != '0))
      else $error("result with empty window");

endmodule
